### rtl/csem_pkg.sv
// Package for the counting semaphore with FIFO wait queue.
// Holds the request and result word types, operation and error codes, sizes.
// No dependencies.
package csem_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PID_W       = 15;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned CFG_W       = 8;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;

  localparam logic MODE_WAIT = 1'b0;
  localparam logic MODE_POST = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_FULL = 2'd1,
    ERR_SAT  = 2'd2
  } csem_err_e;

  typedef struct packed {
    logic             mode;
    logic [PID_W-1:0] caller_pid;
  } csem_req_t;

  typedef struct packed {
    logic             caller_blocks;
    logic             wake_valid;
    logic [PID_W-1:0] wake_pid;
    csem_err_e        error_code;
    logic             queue_empty;
  } csem_rsp_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic load;
  } csem_cmd_t;

endpackage

### rtl/csem_ctrl.sv
// Controller for the counting semaphore: sequences accept, execute, result strobe, and gates config loads.
// Depends on csem_pkg.
module csem_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              cfg_valid_i,
  output logic              busy_o,
  output logic              cfg_ready_o,
  output logic              done_o,
  output csem_pkg::csem_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_EXEC);
    end
  end

  assign busy_o      = (state_q == ST_EXEC);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign done_o      = done_q;

  assign cmd_o.accept = start_i && (state_q == ST_IDLE);
  assign cmd_o.exec   = (state_q == ST_EXEC);
  assign cmd_o.load   = cfg_valid_i && (state_q == ST_IDLE);

endmodule

### rtl/csem_dp.sv
// Datapath for the counting semaphore: count, wait queue memory, pointers, result word.
// Depends on csem_pkg; driven by csem_ctrl commands.
module csem_dp #(
  parameter int unsigned QueueDepth = csem_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  csem_pkg::csem_cmd_t             cmd_i,
  input  csem_pkg::csem_req_t             req_i,
  input  logic [csem_pkg::CFG_W-1:0]      cfg_data_i,
  output csem_pkg::csem_rsp_t             rsp_o
);

  localparam int unsigned PtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW  = $clog2(QueueDepth + 1);
  localparam int unsigned CountW = csem_pkg::COUNT_W;
  localparam int unsigned PidW   = csem_pkg::PID_W;

  logic [PidW-1:0]          mem_q [QueueDepth];
  logic [PidW-1:0]          rd_q;
  csem_pkg::csem_req_t      req_q;
  csem_pkg::csem_rsp_t      rsp_q, rsp_d;

  logic signed [CountW-1:0] count_q, count_d;
  logic [PtrW-1:0]          head_q, head_d, tail_q, tail_d;
  logic [FillW-1:0]         fill_q, fill_d;
  logic                     push, pop;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    tail_d  = tail_q;
    fill_d  = fill_q;
    push    = 1'b0;
    pop     = 1'b0;
    rsp_d.caller_blocks = 1'b0;
    rsp_d.wake_valid    = 1'b0;
    rsp_d.wake_pid      = '0;
    rsp_d.error_code    = csem_pkg::ERR_OK;

    if (req_q.mode == csem_pkg::MODE_WAIT) begin
      if (count_q <= 16'sd0) begin
        if (fill_q == FillW'(QueueDepth)) begin
          rsp_d.error_code = csem_pkg::ERR_FULL;
        end else begin
          push                = 1'b1;
          count_d             = count_q - 16'sd1;
          tail_d              = next_ptr(tail_q);
          fill_d              = fill_q + 1'b1;
          rsp_d.caller_blocks = 1'b1;
        end
      end else begin
        count_d = count_q - 16'sd1;
      end
    end else begin
      if (count_q == csem_pkg::COUNT_MAX) begin
        rsp_d.error_code = csem_pkg::ERR_SAT;
      end else begin
        count_d = count_q + 16'sd1;
        // release the oldest waiter while the count stays at or below zero
        if ((count_q < 16'sd0) && (fill_q != '0)) begin
          pop              = 1'b1;
          head_d           = next_ptr(head_q);
          fill_d           = fill_q - 1'b1;
          rsp_d.wake_valid = 1'b1;
          rsp_d.wake_pid   = rd_q;
        end
      end
    end

    rsp_d.queue_empty = (fill_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
    end else if (cmd_i.load) begin
      count_q <= CountW'(cfg_data_i);
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
    end
  end

  // capture the request and prefetch the head entry at accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
      rd_q  <= mem_q[head_q];
    end
    if (cmd_i.exec && push) begin
      mem_q[tail_q] <= req_q.caller_pid;
    end
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(QueueDepth))
    else $error("wait queue fill exceeds depth");

  a_neg_count_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q < 16'sd0) |-> (CountW'(fill_q) == CountW'(-count_q)))
    else $error("negative count does not match queue fill");

  a_pos_count_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= 16'sd0) |-> (fill_q == '0))
    else $error("waiters queued while count is not negative");

  a_pop_only_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && pop) |-> (req_q.mode == csem_pkg::MODE_POST && !push))
    else $error("dequeue outside a post");

endmodule

### rtl/counting_semaphore_fifo_waiters_top.sv
// Top level of the counting semaphore with FIFO wait queue.
// Depends on csem_pkg, csem_ctrl and csem_dp.
//
//   channel   handshake                    word
//   request   start_i, busy_o              req_i  (mode, caller_pid)
//   result    done_o strobe, no stall      rsp_o  (caller_blocks .. queue_empty)
//   config    cfg_valid_i, cfg_ready_o     cfg_data_i (initial_count)
//
// Each request is accepted, executed in the next cycle, and its result is strobed on
// done_o in the cycle after that, when a new request may be accepted.
// Reset clears the count, queue pointers and fill; queue entries are not cleared.
// The receiver cannot stall; configuration is taken only while busy_o is low.
module counting_semaphore_fifo_waiters_top #(
  parameter int unsigned QueueDepth = csem_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  csem_pkg::csem_req_t        req_i,
  output logic                       done_o,
  output csem_pkg::csem_rsp_t        rsp_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [csem_pkg::CFG_W-1:0] cfg_data_i
);

  csem_pkg::csem_cmd_t cmd;

  csem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cfg_valid_i (cfg_valid_i),
    .busy_o      (busy_o),
    .cfg_ready_o (cfg_ready_o),
    .done_o      (done_o),
    .cmd_o       (cmd)
  );

  csem_dp #(
    .QueueDepth (QueueDepth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_i      (req_i),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (rsp_o)
  );

endmodule
